>>> hw/rtl/lfk_pkg.sv
// lfk_pkg: shared constants for the leg forward kinematics block
// sine polynomial coefficients, corner mounting tables, register and point codes
// no dependencies
package lfk_pkg;

  localparam int ANG_W  = 16;
  localparam int OUT_W  = 24;
  localparam int POS_W  = 26;
  localparam int LEN_W  = 16;
  localparam int CIDX_W = 3;

  localparam logic [ANG_W-1:0] QUARTER = 16'd16384;

  // quarter-wave sine polynomial, Q30, innermost coefficient first
  localparam logic [30:0] SIN_C11 = 31'd3864;
  localparam logic [30:0] SIN_C [5] = '{31'd172272, 31'd5026995, 31'd85569306,
                                        31'd693598668, 31'd1686629713};
  localparam logic [31:0] Q30_ONE = 32'd1073741824;

  // angle slots of the sine bank, sine at 2*slot, cosine at 2*slot+1
  localparam int ANG_YAW   = 0;
  localparam int ANG_PITCH = 1;
  localparam int ANG_ROLL  = 2;
  localparam int ANG_MOUNT = 3;
  localparam int ANG_HIP   = 4;
  localparam int ANG_KNEE  = 5;
  localparam int ANG_ANKLE = 6;
  localparam int NUM_ANG   = 7;

  // mounting yaw of each corner and the sign of its hip offset
  localparam logic [ANG_W-1:0] MOUNT_ANG [4] = '{16'd40960, 16'd57344, 16'd24576, 16'd8192};
  localparam logic [3:0] MOUNT_NEG_X = 4'b1100;
  localparam logic [3:0] MOUNT_NEG_Y = 4'b0101;

  localparam logic signed [POS_W-1:0] SAT_MAX = POS_W'(8388607);
  localparam logic signed [POS_W-1:0] SAT_MIN = -POS_W'(8388608);

  localparam logic [1:0] POINT_MOUNT = 2'd0;
  localparam logic [1:0] POINT_FOOT  = 2'd3;

  typedef enum logic [CIDX_W-1:0] {
    REG_LINK1 = 3'd0,
    REG_LINK2 = 3'd1,
    REG_LINK3 = 3'd2,
    REG_MOUNT = 3'd3
  } cfg_reg_t;

endpackage

>>> hw/rtl/lfk_sine.sv
// lfk_sine: eight-stage pipelined fixed-point sine of a binary angle
// at most one multiplier per stage, odd polynomial over a quarter wave
// depends on lfk_pkg
module lfk_sine #(
  parameter int FRAC = 14
) (
  input  logic                        clk,
  input  logic                        en,
  input  logic [lfk_pkg::ANG_W-1:0]   angle,
  output logic signed [FRAC+1:0]      value
);
  import lfk_pkg::*;

  logic [1:0]  q  [7];
  logic [30:0] t  [6];
  logic [30:0] t2 [5];
  logic [30:0] p  [5];
  logic [31:0] s;
  logic [14:0] r;
  logic [30:0] tt;
  logic [61:0] sq;
  logic [61:0] prd [5];
  logic [61:0] sp;
  logic [31:0] sc;
  logic [31:0] sr;
  logic [FRAC:0] mag;

  // fold the angle into the first quarter
  assign r  = angle[14] ? 15'd16384 - {1'b0, angle[13:0]} : {1'b0, angle[13:0]};
  assign tt = {r, 16'b0};
  assign sq = tt * tt;

  always_ff @(posedge clk) begin
    if (en) begin
      q[0]  <= angle[15:14];
      t[0]  <= tt;
      t2[0] <= sq[60:30];
    end
  end

  for (genvar k = 0; k < 5; k++) begin : g_poly
    if (k == 0) begin : g_first
      assign prd[k] = t2[k] * SIN_C11;
    end else begin : g_next
      assign prd[k] = t2[k] * p[k-1];
    end
    always_ff @(posedge clk) begin
      if (en) begin
        p[k]   <= 31'({1'b0, SIN_C[k]} - prd[k][61:30]);
        q[k+1] <= q[k];
        t[k+1] <= t[k];
        if (k < 4) begin
          t2[k+1] <= t2[k];
        end
      end
    end
  end

  assign sp = t[5] * p[4];

  always_ff @(posedge clk) begin
    if (en) begin
      s    <= sp[61:30];
      q[6] <= q[5];
    end
  end

  // clamp to one, round half up, apply quadrant sign
  assign sc  = (s > Q30_ONE) ? Q30_ONE : s;
  assign sr  = sc + (32'd1 << (29 - FRAC));
  assign mag = sr[30:30-FRAC];

  always_ff @(posedge clk) begin
    if (en) begin
      value <= q[6][1] ? -$signed({1'b0, mag}) : $signed({1'b0, mag});
    end
  end

endmodule

>>> hw/rtl/lfk_compose.sv
// lfk_compose: two-stage product of two rigid transforms
// stage one forms all partial products, stage two sums, rounds and translates
// depends on lfk_pkg
module lfk_compose #(
  parameter int RW   = 17,
  parameter int FRAC = 14
) (
  input  logic                              clk,
  input  logic                              en,
  input  logic signed [RW-1:0]              a_r [9],
  input  logic signed [lfk_pkg::POS_W-1:0]  a_p [3],
  input  logic signed [RW-1:0]              b_r [9],
  input  logic signed [lfk_pkg::POS_W-1:0]  b_p [3],
  output logic signed [RW-1:0]              o_r [9],
  output logic signed [lfk_pkg::POS_W-1:0]  o_p [3]
);
  import lfk_pkg::*;

  localparam int MW = 2 * RW;
  localparam int TW = RW + POS_W;

  logic signed [MW-1:0]    mr [27];
  logic signed [TW-1:0]    mt [9];
  logic signed [POS_W-1:0] ap_q [3];
  logic signed [MW+1:0]    racc [9];
  logic signed [MW+1:0]    rsh [9];
  logic signed [TW+1:0]    tacc [3];
  logic signed [TW+1:0]    tsh [3];

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        for (int j = 0; j < 3; j++) begin
          for (int k = 0; k < 3; k++) begin
            mr[i*9+j*3+k] <= a_r[i*3+k] * b_r[k*3+j];
          end
        end
        for (int k = 0; k < 3; k++) begin
          mt[i*3+k] <= a_r[i*3+k] * b_p[k];
        end
        ap_q[i] <= a_p[i];
      end
    end
  end

  // round to nearest, ties up, by arithmetic shift of the biased sum
  always_comb begin
    for (int n = 0; n < 9; n++) begin
      racc[n] = (MW+2)'(mr[n*3]) + (MW+2)'(mr[n*3+1]) + (MW+2)'(mr[n*3+2])
                + ((MW+2)'(1) <<< (FRAC - 1));
      rsh[n]  = racc[n] >>> FRAC;
    end
    for (int i = 0; i < 3; i++) begin
      tacc[i] = (TW+2)'(mt[i*3]) + (TW+2)'(mt[i*3+1]) + (TW+2)'(mt[i*3+2])
                + ((TW+2)'(1) <<< (FRAC - 1));
      tsh[i]  = tacc[i] >>> FRAC;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int n = 0; n < 9; n++) begin
        o_r[n] <= rsh[n][RW-1:0];
      end
      for (int i = 0; i < 3; i++) begin
        o_p[i] <= ap_q[i] + tsh[i][POS_W-1:0];
      end
    end
  end

endmodule

>>> hw/rtl/lfk_serializer.sv
// lfk_serializer: holds the four points of one pose and sends them one per request
// saturates each coordinate to the output range on load
// depends on lfk_pkg
module lfk_serializer (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              load_valid,
  input  logic signed [lfk_pkg::POS_W-1:0]  pts [4][3],
  output logic                              take,
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic [1:0]                        point_index,
  output logic signed [lfk_pkg::OUT_W-1:0]  point_x,
  output logic signed [lfk_pkg::OUT_W-1:0]  point_y,
  output logic signed [lfk_pkg::OUT_W-1:0]  point_z,
  output logic                              last_point
);
  import lfk_pkg::*;

  logic signed [OUT_W-1:0] hold [4][3];
  logic [1:0] idx;
  logic busy;

  function automatic logic signed [OUT_W-1:0] sat(input logic signed [POS_W-1:0] v);
    logic signed [POS_W-1:0] c;
    c = (v > SAT_MAX) ? SAT_MAX : ((v < SAT_MIN) ? SAT_MIN : v);
    return c[OUT_W-1:0];
  endfunction

  assign take = !busy || (idx == POINT_FOOT && out_ready);

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      idx  <= POINT_MOUNT;
    end else if (load_valid && take) begin
      busy <= 1'b1;
      idx  <= POINT_MOUNT;
    end else if (busy && out_ready) begin
      if (idx == POINT_FOOT) begin
        busy <= 1'b0;
      end else begin
        idx <= idx + 2'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load_valid && take) begin
      for (int i = 0; i < 4; i++) begin
        for (int c = 0; c < 3; c++) begin
          hold[i][c] <= sat(pts[i][c]);
        end
      end
    end
  end

  assign out_valid   = busy;
  assign point_index = idx;
  assign point_x     = hold[idx][0];
  assign point_y     = hold[idx][1];
  assign point_z     = hold[idx][2];
  assign last_point  = (idx == POINT_FOOT);

  a_step: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_ready && !last_point |=>
      out_valid && point_index == $past(point_index) + 2'd1)
    else $error("point sequence skipped or stopped early");

  a_load: assert property (@(posedge clk) disable iff (rst)
    load_valid && take |=> out_valid && point_index == POINT_MOUNT)
    else $error("new pose did not start at the mount point");

endmodule

>>> hw/rtl/leg_forward_kinematics_top.sv
// leg_forward_kinematics_top: world positions of mount, joints and foot of one leg
// instantiates lfk_sine, lfk_compose and lfk_serializer; depends on lfk_pkg
//
// A pose request (leg, three joint angles, body position and attitude) enters on
// in_valid/in_ready. Each request yields four points on out_valid/out_ready in
// order mount, second joint, third joint, foot; last_point marks the foot.
// Lengths and the hip offset are set through cfg_write/cfg_index/cfg_data; the
// user must write them only while the block is idle, which the block does not
// enforce; an unknown index is ignored. The first point of a request follows
// the datapath and the serializer's hold register; the other three follow one
// per cycle while out_ready is high. The four-point output port sets the
// request rate; the 22-stage datapath (8-stage sine bank, link prep, six
// 2-stage transform products) itself takes a request every cycle unless stalled.
// A stall at the output freezes the whole datapath; in_ready falls only when
// the last stage holds a pose that the output register cannot yet take.
// Reset clears all valid bits and loads the default link lengths and offset.
module leg_forward_kinematics_top #(
  parameter int TRIG_FRAC_BITS = 14
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               in_valid,
  output logic                               in_ready,
  input  logic [1:0]                         leg_select,
  input  logic signed [15:0]                 hip_angle,
  input  logic signed [15:0]                 knee_angle,
  input  logic signed [15:0]                 ankle_angle,
  input  logic signed [23:0]                 body_x,
  input  logic signed [23:0]                 body_y,
  input  logic signed [23:0]                 body_z,
  input  logic signed [15:0]                 body_roll,
  input  logic signed [15:0]                 body_pitch,
  input  logic signed [15:0]                 body_yaw,
  output logic                               out_valid,
  input  logic                               out_ready,
  output logic [1:0]                         point_index,
  output logic signed [23:0]                 point_x,
  output logic signed [23:0]                 point_y,
  output logic signed [23:0]                 point_z,
  output logic                               last_point,
  input  logic                               cfg_write,
  input  logic [lfk_pkg::CIDX_W-1:0]         cfg_index,
  input  logic [lfk_pkg::LEN_W-1:0]          cfg_data
);
  import lfk_pkg::*;

  localparam int F   = TRIG_FRAC_BITS;
  localparam int TW  = F + 2;
  localparam int RW  = F + 3;
  localparam int PW  = POS_W;
  localparam int LPW = 18 + TW;
  localparam int LAT = 22;
  localparam int NS  = 2 * NUM_ANG;
  localparam logic signed [RW-1:0] ONE_R = RW'(1) <<< F;

  typedef struct packed {
    logic [1:0]         leg;
    logic signed [23:0] bx;
    logic signed [23:0] by;
    logic signed [23:0] bz;
  } pose_t;

  typedef struct {
    logic signed [RW-1:0] rz[9], ry[9], rx[9], rm[9];
    logic signed [PW-1:0] mp[3];
    logic signed [RW-1:0] lr[3][9];
    logic signed [PW-1:0] lp[3][3];
    logic signed [PW-1:0] bpos[3];
    logic signed [PW-1:0] pts[3][3];
  } carry_t;

  logic [LEN_W-1:0] link1_length, link2_length, link3_length, mount_offset;
  logic en;
  logic take;
  logic [LAT-1:0] vld;
  pose_t in_d [8];
  logic [ANG_W-1:0] ang [NUM_ANG];
  logic signed [TW-1:0] sv [NS];
  logic signed [TW-1:0] tr1 [NS];
  logic [1:0] leg1;
  logic signed [PW-1:0] bpos1 [3];
  logic signed [17:0] lsgn [3];
  logic signed [LPW-1:0] lprod [3][2];
  logic signed [LPW-1:0] lrnd [3][2];
  carry_t carry_in;
  carry_t carry [13];
  carry_t carry_next [12];
  logic signed [PW-1:0] zero_p [3];
  logic signed [RW-1:0] c_r [6][9];
  logic signed [PW-1:0] c_p [6][3];
  logic signed [PW-1:0] ser_pts [4][3];

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      link1_length <= 16'd1408;
      link2_length <= 16'd1920;
      link3_length <= 16'd5760;
      mount_offset <= 16'd2625;
    end else if (cfg_write) begin
      unique case (cfg_index)
        REG_LINK1: link1_length <= cfg_data;
        REG_LINK2: link2_length <= cfg_data;
        REG_LINK3: link3_length <= cfg_data;
        REG_MOUNT: mount_offset <= cfg_data;
        default: ;
      endcase
    end
  end

  // whole datapath advances together; stalls only behind a full last stage
  assign en       = !vld[LAT-1] || take;
  assign in_ready = en;

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (en) begin
      vld <= {vld[LAT-2:0], in_valid};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      in_d[0] <= '{leg: leg_select, bx: body_x, by: body_y, bz: body_z};
      for (int i = 1; i < 8; i++) begin
        in_d[i] <= in_d[i-1];
      end
    end
  end

  // sine bank
  assign ang[ANG_YAW]   = body_yaw;
  assign ang[ANG_PITCH] = body_pitch;
  assign ang[ANG_ROLL]  = body_roll;
  assign ang[ANG_MOUNT] = MOUNT_ANG[leg_select];
  assign ang[ANG_HIP]   = hip_angle;
  assign ang[ANG_KNEE]  = knee_angle + QUARTER;
  assign ang[ANG_ANKLE] = ankle_angle;

  for (genvar g = 0; g < NS; g++) begin : g_sin
    localparam int AI = g / 2;
    localparam bit IS_COS = (g % 2) == 1;
    lfk_sine #(.FRAC(F)) u_sine (
      .clk   (clk),
      .en    (en),
      .angle (IS_COS ? ang[AI] + QUARTER : ang[AI]),
      .value (sv[g])
    );
  end

  // link prep, stage one: length times cos and sin
  assign lsgn[0] = $signed({2'b0, link1_length});
  assign lsgn[1] = -$signed({2'b0, link2_length});
  assign lsgn[2] = -$signed({2'b0, link3_length});

  always_ff @(posedge clk) begin
    if (en) begin
      tr1      <= sv;
      leg1     <= in_d[7].leg;
      bpos1[0] <= PW'(in_d[7].bx);
      bpos1[1] <= PW'(in_d[7].by);
      bpos1[2] <= PW'(in_d[7].bz);
      for (int l = 0; l < 3; l++) begin
        lprod[l][0] <= lsgn[l] * sv[2*(ANG_HIP+l)+1];
        lprod[l][1] <= lsgn[l] * sv[2*(ANG_HIP+l)];
      end
    end
  end

  // link prep, stage two: round translations and lay out the matrices
  always_comb begin
    for (int l = 0; l < 3; l++) begin
      for (int c = 0; c < 2; c++) begin
        lrnd[l][c] = (lprod[l][c] + (LPW'(1) <<< (F - 1))) >>> F;
      end
    end
    carry_in = carry[0];
    carry_in.rz = '{RW'(tr1[2*ANG_YAW+1]), -RW'(tr1[2*ANG_YAW]), '0,
                    RW'(tr1[2*ANG_YAW]), RW'(tr1[2*ANG_YAW+1]), '0,
                    '0, '0, ONE_R};
    carry_in.ry = '{RW'(tr1[2*ANG_PITCH+1]), '0, RW'(tr1[2*ANG_PITCH]),
                    '0, ONE_R, '0,
                    -RW'(tr1[2*ANG_PITCH]), '0, RW'(tr1[2*ANG_PITCH+1])};
    carry_in.rx = '{ONE_R, '0, '0,
                    '0, RW'(tr1[2*ANG_ROLL+1]), -RW'(tr1[2*ANG_ROLL]),
                    '0, RW'(tr1[2*ANG_ROLL]), RW'(tr1[2*ANG_ROLL+1])};
    carry_in.rm = '{RW'(tr1[2*ANG_MOUNT+1]), -RW'(tr1[2*ANG_MOUNT]), '0,
                    RW'(tr1[2*ANG_MOUNT]), RW'(tr1[2*ANG_MOUNT+1]), '0,
                    '0, '0, ONE_R};
    carry_in.mp[0] = MOUNT_NEG_X[leg1] ? -PW'(mount_offset) : PW'(mount_offset);
    carry_in.mp[1] = MOUNT_NEG_Y[leg1] ? -PW'(mount_offset) : PW'(mount_offset);
    carry_in.mp[2] = '0;
    // hip link: alpha of a quarter turn
    carry_in.lr[0] = '{RW'(tr1[2*ANG_HIP+1]), '0, RW'(tr1[2*ANG_HIP]),
                       RW'(tr1[2*ANG_HIP]), '0, -RW'(tr1[2*ANG_HIP+1]),
                       '0, ONE_R, '0};
    // knee and ankle links: alpha of a half turn
    for (int l = 1; l < 3; l++) begin
      carry_in.lr[l] = '{RW'(tr1[2*(ANG_HIP+l)+1]), RW'(tr1[2*(ANG_HIP+l)]), '0,
                         RW'(tr1[2*(ANG_HIP+l)]), -RW'(tr1[2*(ANG_HIP+l)+1]), '0,
                         '0, '0, -ONE_R};
    end
    for (int l = 0; l < 3; l++) begin
      carry_in.lp[l][0] = lrnd[l][0][PW-1:0];
      carry_in.lp[l][1] = lrnd[l][1][PW-1:0];
      carry_in.lp[l][2] = '0;
    end
    carry_in.bpos = bpos1;
  end

  // side data travels beside the transform products; points drop in as made
  always_comb begin
    for (int k = 0; k < 12; k++) begin
      carry_next[k] = carry[k];
    end
    carry_next[6].pts[0]  = c_p[2];
    carry_next[8].pts[1]  = c_p[3];
    carry_next[10].pts[2] = c_p[4];
  end

  always_ff @(posedge clk) begin
    if (en) begin
      carry[0] <= carry_in;
      for (int k = 0; k < 12; k++) begin
        carry[k+1] <= carry_next[k];
      end
    end
  end

  assign zero_p = '{'0, '0, '0};

  // yaw times pitch, carrying the body position as translation
  lfk_compose #(.RW(RW), .FRAC(F)) u_body_zy (
    .clk (clk), .en (en),
    .a_r (carry[0].rz), .a_p (carry[0].bpos),
    .b_r (carry[0].ry), .b_p (zero_p),
    .o_r (c_r[0]), .o_p (c_p[0])
  );

  lfk_compose #(.RW(RW), .FRAC(F)) u_body_x (
    .clk (clk), .en (en),
    .a_r (c_r[0]), .a_p (c_p[0]),
    .b_r (carry[2].rx), .b_p (zero_p),
    .o_r (c_r[1]), .o_p (c_p[1])
  );

  lfk_compose #(.RW(RW), .FRAC(F)) u_mount (
    .clk (clk), .en (en),
    .a_r (c_r[1]), .a_p (c_p[1]),
    .b_r (carry[4].rm), .b_p (carry[4].mp),
    .o_r (c_r[2]), .o_p (c_p[2])
  );

  lfk_compose #(.RW(RW), .FRAC(F)) u_hip (
    .clk (clk), .en (en),
    .a_r (c_r[2]), .a_p (c_p[2]),
    .b_r (carry[6].lr[0]), .b_p (carry[6].lp[0]),
    .o_r (c_r[3]), .o_p (c_p[3])
  );

  lfk_compose #(.RW(RW), .FRAC(F)) u_knee (
    .clk (clk), .en (en),
    .a_r (c_r[3]), .a_p (c_p[3]),
    .b_r (carry[8].lr[1]), .b_p (carry[8].lp[1]),
    .o_r (c_r[4]), .o_p (c_p[4])
  );

  lfk_compose #(.RW(RW), .FRAC(F)) u_ankle (
    .clk (clk), .en (en),
    .a_r (c_r[4]), .a_p (c_p[4]),
    .b_r (carry[10].lr[2]), .b_p (carry[10].lp[2]),
    .o_r (c_r[5]), .o_p (c_p[5])
  );

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      ser_pts[i] = carry[12].pts[i];
    end
    ser_pts[3] = c_p[5];
  end

  lfk_serializer u_ser (
    .clk         (clk),
    .rst         (rst),
    .load_valid  (vld[LAT-1]),
    .pts         (ser_pts),
    .take        (take),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .point_index (point_index),
    .point_x     (point_x),
    .point_y     (point_y),
    .point_z     (point_z),
    .last_point  (last_point)
  );

  a_free: assert property (@(posedge clk) disable iff (rst)
    !vld[LAT-1] |-> in_ready)
    else $error("intake blocked with an empty last stage");

  a_hold: assert property (@(posedge clk) disable iff (rst)
    !in_ready |=> $stable(vld))
    else $error("pipeline moved during a stall");

endmodule
